// File: rtl/core/pei_pkg.sv
// shared types and constants for the polynomial easing interpolator
package pei_pkg;

  // fixed-point constants, q1.16 time domain
  localparam int unsigned TimeW    = 17;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned ProdW    = DiffW + TimeW + 1;
  localparam int unsigned Lanes    = 3;
  localparam int unsigned PowStages = 4;

  // pipeline depth: prep, power stages, ease, blend multiply, blend round
  localparam int unsigned NStages  = PowStages + 4;

  localparam logic [TimeW-1:0] ONE_Q16  = 17'd65536;
  localparam logic [TimeW-1:0] HALF_Q16 = 17'd32768;

  // stream widths
  localparam int unsigned InDataW  = 216;
  localparam int unsigned OutDataW = 96;

  // configuration register indexes
  localparam logic REG_POWER     = 1'b0;
  localparam logic REG_DIRECTION = 1'b1;

  // curve power codes
  localparam logic [2:0] POW_LINEAR = 3'd1;
  localparam logic [2:0] POW_QUINT  = 3'd5;

  // curve direction codes
  localparam logic [1:0] DIR_IN    = 2'd0;
  localparam logic [1:0] DIR_OUT   = 2'd1;
  localparam logic [1:0] DIR_INOUT = 2'd2;

  typedef logic [Lanes-1:0][CoordW-1:0] coord_vec_t;
  typedef logic [Lanes-1:0][DiffW-1:0]  diff_vec_t;

  // context that travels with an item through the power stages
  typedef struct packed {
    logic [TimeW-1:0] u;
    logic [2:0]       n;
    logic [1:0]       dir;
    logic             upper;
    coord_vec_t       a;
    diff_vec_t        d;
  } ctx_t;

endpackage

// File: rtl/core/polynomial_easing_interpolator_top.sv
// Polynomial easing interpolator: eight-stage pipeline, one request per cycle unless out_tready stalls it.
// An accepted request passes through prep, four power multiply stages, ease,
// blend multiply and blend round/output before its result is valid.
// Throughput: one request per clock while out_tready is high; each stage holds until its successor
// frees, so bubbles are squeezed out and a stall drops nothing.
// Reset (rst_n, synchronous): pipeline emptied, curve_power = 1, direction = in.
module polynomial_easing_interpolator_top
  import pei_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z (32 each), time_fraction (17), zero pad
  input  logic [InDataW-1:0]  in_tdata,
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  // pos_x, pos_y, pos_z (32 each)
  output logic [OutDataW-1:0] out_tdata,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [2:0]          cfg_data
);

  // configuration registers
  logic [2:0] curve_power_r;
  logic [1:0] curve_direction_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_power_r     <= POW_LINEAR;
      curve_direction_r <= DIR_IN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POWER:     curve_power_r     <= cfg_data;
        REG_DIRECTION: curve_direction_r <= cfg_data[1:0];
        default:       ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic [NStages-1:0] valid_r;
  logic [NStages:0]   adv;

  always_comb begin
    adv[NStages] = out_tready;
    for (int k = NStages - 1; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NStages; k++) begin
        if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // stage 0: unpack, clamp codes, saturate time, pick polynomial base
  ctx_t             prep_ctx;
  logic [TimeW-1:0] t_raw;
  logic [TimeW-1:0] t_sat;
  logic [TimeW:0]   t_dbl;
  logic [TimeW:0]   t_rev;

  always_comb begin
    t_raw = in_tdata[6*CoordW +: TimeW];
    t_sat = (t_raw > ONE_Q16) ? ONE_Q16 : t_raw;
    t_dbl = {t_sat, 1'b0};
    t_rev = {ONE_Q16, 1'b0} - t_dbl;

    if (curve_power_r == 3'd0)          prep_ctx.n = POW_LINEAR;
    else if (curve_power_r > POW_QUINT) prep_ctx.n = POW_QUINT;
    else                                prep_ctx.n = curve_power_r;

    prep_ctx.dir   = (curve_direction_r == DIR_IN || curve_direction_r == DIR_OUT)
                     ? curve_direction_r : DIR_INOUT;
    prep_ctx.upper = (t_sat >= HALF_Q16);

    unique case (prep_ctx.dir)
      DIR_IN:  prep_ctx.u = t_sat;
      DIR_OUT: prep_ctx.u = ONE_Q16 - t_sat;
      default: prep_ctx.u = prep_ctx.upper ? t_rev[TimeW-1:0] : t_dbl[TimeW-1:0];
    endcase

    for (int l = 0; l < Lanes; l++) begin
      prep_ctx.a[l] = in_tdata[l*CoordW +: CoordW];
      prep_ctx.d[l] = DiffW'($signed(in_tdata[(l+Lanes)*CoordW +: CoordW]))
                    - DiffW'($signed(in_tdata[l*CoordW +: CoordW]));
    end
  end

  // stages 0..4: context and running power
  ctx_t             ctx_r [PowStages+1];
  logic [TimeW-1:0] pw_r  [PowStages+1];
  logic [TimeW-1:0] pw_nxt [1:PowStages];
  logic [2*TimeW:0] pw_prod [1:PowStages];

  // power stage k applies the k-th rounded multiply when the power calls for it
  always_comb begin
    for (int k = 1; k <= PowStages; k++) begin
      pw_prod[k] = (2*TimeW+1)'(pw_r[k-1]) * (2*TimeW+1)'(ctx_r[k-1].u)
                 + (2*TimeW+1)'(HALF_Q16);
      pw_nxt[k]  = (3'(k) < ctx_r[k-1].n) ? pw_prod[k][16 +: TimeW] : pw_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ctx_r[0] <= prep_ctx;
      pw_r[0]  <= prep_ctx.u;
    end
    for (int k = 1; k <= PowStages; k++) begin
      if (adv[k]) begin
        ctx_r[k] <= ctx_r[k-1];
        pw_r[k]  <= pw_nxt[k];
      end
    end
  end

  // stage 5: eased time from the power and direction
  logic [TimeW-1:0] ease_nxt;
  logic [TimeW:0]   pw_half;
  logic [TimeW-1:0] ease_r;
  coord_vec_t       a5_r;
  diff_vec_t        d5_r;

  always_comb begin
    pw_half = ((TimeW+1)'(pw_r[PowStages]) + 18'd1) >> 1;
    unique case (ctx_r[PowStages].dir)
      DIR_IN:  ease_nxt = pw_r[PowStages];
      DIR_OUT: ease_nxt = ONE_Q16 - pw_r[PowStages];
      default: ease_nxt = ctx_r[PowStages].upper ? ONE_Q16 - pw_half[TimeW-1:0]
                                                 : pw_half[TimeW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[PowStages+1]) begin
      ease_r <= ease_nxt;
      a5_r   <= ctx_r[PowStages].a;
      d5_r   <= ctx_r[PowStages].d;
    end
  end

  // stage 6: difference times eased time per lane
  logic signed [ProdW-1:0] prod_r [Lanes];
  coord_vec_t              a6_r;

  always_ff @(posedge clk) begin
    if (adv[PowStages+2]) begin
      a6_r <= a5_r;
      for (int l = 0; l < Lanes; l++) begin
        prod_r[l] <= ProdW'($signed(d5_r[l]) * $signed({1'b0, ease_r}));
      end
    end
  end

  // stage 7: round the product and add the start point
  logic [ProdW-1:0]   prod_rnd [Lanes];
  coord_vec_t         pos_nxt;
  logic [OutDataW-1:0] out_r;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      prod_rnd[l] = prod_r[l] + ProdW'(HALF_Q16);
      pos_nxt[l]  = a6_r[l] + prod_rnd[l][16 +: CoordW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[PowStages+3]) begin
      out_r <= pos_nxt;
    end
  end

  assign out_tvalid = valid_r[NStages-1];
  assign out_tdata  = out_r;

endmodule
